// ----- rtl/kstf_pkg.sv -----
// Shared constants and types for the k-smallest timing filter.
package kstf_pkg;

  localparam int DEPTH_DEFAULT = 10;
  localparam int SAMPLE_W      = 32;
  localparam int COUNT_W       = 4;
  localparam int TOL_W         = 8;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 32;

  localparam logic [TOL_W-1:0]    TOL_RESET  = 8'd51;
  localparam logic [SAMPLE_W-1:0] CEIL_RESET = 32'd900000000;

  localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CEILING   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_HI,
    S_MUL_LO,
    S_CHECK,
    S_WALK,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

// ----- rtl/k_smallest_timing_filter_core.sv -----
// Top level of the k-smallest timing filter: sorted list, band test and running average.
// Steps per sample: accept, high and low band multiplies, band check, a walk over every list entry,
// a restoring divide (skipped when rejected or no entry counts), then finish.
// A new sample is accepted only in idle, after the previous result has been loaded for output.
// The rotating list walk and the one-bit-per-cycle divider set how soon the next sample is taken.
// Synchronous reset: list all ones, average zero and unseeded, registers to defaults.
module k_smallest_timing_filter_core #(
  parameter int DEPTH = kstf_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [kstf_pkg::SAMPLE_W-1:0]    sample_time,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             rejected,
  output logic [kstf_pkg::SAMPLE_W-1:0]    average,
  output logic [kstf_pkg::COUNT_W-1:0]     filled_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kstf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kstf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kstf_pkg::*;

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int SW     = SAMPLE_W + CW;
  localparam int DCW    = $clog2(SW);
  localparam int NW     = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int FW     = TOL_W + 1;
  localparam int PW     = SAMPLE_W + FW;

  state_t state, state_next;

  logic [SAMPLE_W-1:0] times [DEPTH];
  logic [SAMPLE_W-1:0] avg;
  logic                seeded;
  logic [TOL_W-1:0]    tol;
  logic [SAMPLE_W-1:0] ceil_val;
  logic [SAMPLE_W-1:0] sample;
  logic                rej;
  logic                rej_hi;
  logic [PW-1:0]       prod;
  logic                inserted;
  logic [SAMPLE_W-1:0] carry;
  logic [IDX_W-1:0]    walk_cnt;
  logic [SW-1:0]       sum;
  logic [CW-1:0]       n;
  logic [CW-1:0]       rem;
  logic [DCW-1:0]      div_cnt;

  logic                accept;
  logic                load_out;
  logic                walk_last;
  logic                div_last;
  logic [FW-1:0]       factor;
  logic [PW-1:0]       prod_next;
  logic [PW-1:0]       scaled;
  logic [SAMPLE_W-1:0] head;
  logic                take_new;
  logic [SAMPLE_W-1:0] push;
  logic                counts;
  logic [SW-1:0]       sum_next;
  logic [CW-1:0]       n_next;
  logic [CW:0]         rem_sh;
  logic                rem_ge;
  logic [CW:0]         rem_sub;
  logic [CW-1:0]       rem_next;
  logic [SW-1:0]       quo_next;
  logic [NW-1:0]       n_wide;

  // shared multiplier for both band edges
  assign factor    = (state == S_MUL_HI) ? (FW'(256) + FW'(tol)) : (FW'(256) - FW'(tol));
  assign prod_next = PW'(avg) * PW'(factor);
  assign scaled    = PW'({sample, 8'b0});

  // rotating walk: insert while passing entries through the head
  assign head     = times[0];
  assign take_new = !rej && !inserted && (sample < head);
  assign push     = take_new ? sample : (inserted ? carry : head);
  assign counts   = push < ceil_val;
  assign sum_next = counts ? (sum + SW'(push)) : sum;
  assign n_next   = counts ? (n + CW'(1)) : n;

  // restoring divider step, quotient shifts into the sum register
  assign rem_sh   = {rem, sum[SW-1]};
  assign rem_ge   = rem_sh >= {1'b0, n};
  assign rem_sub  = rem_sh - {1'b0, n};
  assign rem_next = rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
  assign quo_next = {sum[SW-2:0], rem_ge};

  assign walk_last = walk_cnt == IDX_W'(DEPTH - 1);
  assign div_last  = div_cnt == DCW'(SW - 1);
  assign n_wide    = NW'(n);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_MUL_LO;
      S_MUL_LO: state_next = S_CHECK;
      S_CHECK:  state_next = S_WALK;
      S_WALK: begin
        if (walk_last) begin
          state_next = (rej || (n_next == '0)) ? S_FINISH : S_DIV;
        end
      end
      S_DIV:    if (div_last) state_next = S_FINISH;
      S_FINISH: if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state == S_IDLE;
    cfg_ready = 1'b1;
    accept    = in_valid && (state == S_IDLE);
    load_out  = (state == S_FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol      <= TOL_RESET;
      ceil_val <= CEIL_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TOLERANCE) tol <= cfg_data[TOL_W-1:0];
      if (cfg_index == CFG_CEILING) ceil_val <= cfg_data[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) times[i] <= '1;
    end else if (state == S_WALK) begin
      for (int i = 0; i < DEPTH - 1; i++) times[i] <= times[i+1];
      times[DEPTH-1] <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg    <= '0;
      seeded <= 1'b0;
    end else if (accept && !seeded) begin
      avg    <= sample_time;
      seeded <= 1'b1;
    end else if ((state == S_DIV) && div_last) begin
      avg <= quo_next[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        sample   <= sample_time;
        inserted <= 1'b0;
        walk_cnt <= '0;
        sum      <= '0;
        n        <= '0;
      end
      S_MUL_HI: prod <= prod_next;
      S_MUL_LO: begin
        rej_hi <= scaled > prod;
        prod   <= prod_next;
      end
      S_CHECK: rej <= rej_hi || (scaled < prod);
      S_WALK: begin
        carry    <= head;
        inserted <= inserted || take_new;
        walk_cnt <= walk_cnt + IDX_W'(1);
        sum      <= sum_next;
        n        <= n_next;
        rem      <= '0;
        div_cnt  <= '0;
      end
      S_DIV: begin
        rem     <= rem_next;
        sum     <= quo_next;
        div_cnt <= div_cnt + DCW'(1);
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rejected     <= rej;
      average      <= avg;
      filled_count <= (n_wide > NW'(15)) ? COUNT_W'(15) : n_wide[COUNT_W-1:0];
    end
  end

endmodule

// ----- rtl/kstf_checker.sv -----
// Port-level assertions for the k-smallest timing filter, bound to the top level.
module kstf_checker #(
  parameter int DEPTH = kstf_pkg::DEPTH_DEFAULT
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             rejected,
  input logic [kstf_pkg::SAMPLE_W-1:0]    average,
  input logic [kstf_pkg::COUNT_W-1:0]     filled_count
);
  import kstf_pkg::*;

  localparam int MAX_FILL = (DEPTH > 15) ? 15 : DEPTH;

  busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready again right after a transaction");

  result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a busy cycle");

  fill_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (filled_count <= COUNT_W'(MAX_FILL)))
    else $error("filled count above list depth");

  result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(average) && $stable(rejected)
      && $stable(filled_count))
    else $error("stalled result changed");

endmodule

bind k_smallest_timing_filter_core kstf_checker #(.DEPTH(DEPTH)) u_kstf_checker (.*);
